/* src/ecd_pkg.sv */
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types, constants and calendar helper functions for the epoch
// seconds to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecd_pkg;

    // Reciprocal constants for exact division of values up to 32 bits.
    localparam logic [31:0] DivMagic60    = 32'h8888_8889;
    localparam int          DivShift60    = 37;
    localparam logic [31:0] DivMagic24    = 32'hAAAA_AAAB;
    localparam int          DivShift24    = 36;

    // Year estimate: days * YearMagic >> YearShift is within one of the year.
    localparam logic [15:0] YearMagic     = 16'd45934;
    localparam int          YearShift     = 24;

    localparam logic [7:0]  Year2100      = 8'd130;
    localparam logic [8:0]  DaysPerYear   = 9'd365;

    typedef logic [15:0] t_days;
    typedef logic [8:0]  t_doy;
    typedef logic [7:0]  t_year;
    typedef logic [3:0]  t_month_idx;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
    } t_hms;

    // Leap rule over the supported span: divisible by four, except 2100.
    function automatic logic is_leap(input t_year year);
        is_leap = (year[1:0] == 2'd2) && (year != Year2100);
    endfunction

    // First day of a year, counted in days from the start of 1970.
    function automatic t_days year_start(input t_year year);
        logic [16:0] base;
        logic [16:0] leaps;
        base  = 17'(year) * 17'(DaysPerYear);
        leaps = (17'(year) + 17'd1) >> 2;
        if (year > Year2100) begin
            leaps = leaps - 17'd1;
        end
        year_start = t_days'(base + leaps);
    endfunction

    // First day of a month within its year, months counted from zero.
    function automatic t_doy month_start(input t_month_idx idx, input logic leap);
        t_doy base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
        end
        month_start = base;
    endfunction

endpackage

`default_nettype wire

/* src/ecd_time_split.sv */
// ----------------------------------------------------------------------------
// ecd_time_split
// Six-stage pipeline that splits a seconds count into second, minute and
// hour of the day and the number of whole days.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_time_split
    import ecd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_seconds,
    output logic             o_valid,
    output t_days            o_days,
    output t_hms             o_hms
);

    logic        r_s1_valid;
    logic [31:0] r_s1_t;
    logic [63:0] r_s1_prod;

    logic        r_s2_valid;
    logic [26:0] r_s2_q;
    logic [5:0]  r_s2_sec;

    logic        r_s3_valid;
    logic [26:0] r_s3_q;
    logic [58:0] r_s3_prod;
    logic [5:0]  r_s3_sec;

    logic        r_s4_valid;
    logic [20:0] r_s4_q;
    logic [5:0]  r_s4_sec;
    logic [5:0]  r_s4_min;

    logic        r_s5_valid;
    logic [20:0] r_s5_q;
    logic [52:0] r_s5_prod;
    logic [5:0]  r_s5_sec;
    logic [5:0]  r_s5_min;

    logic        r_s6_valid;
    t_days       r_s6_days;
    t_hms        r_s6_hms;

    logic [26:0] n_s2_q;
    logic [32:0] n_s2_qx60;
    logic [5:0]  n_s2_sec;
    logic [20:0] n_s4_q;
    logic [26:0] n_s4_qx60;
    logic [5:0]  n_s4_min;
    t_days       n_s6_days;
    logic [20:0] n_s6_dx24;
    logic [4:0]  n_s6_hour;

    always_comb begin
        n_s2_q    = r_s1_prod[DivShift60 +: 27];
        n_s2_qx60 = (33'(n_s2_q) << 6) - (33'(n_s2_q) << 2);
        n_s2_sec  = 6'(r_s1_t - n_s2_qx60[31:0]);

        n_s4_q    = r_s3_prod[DivShift60 +: 21];
        n_s4_qx60 = (27'(n_s4_q) << 6) - (27'(n_s4_q) << 2);
        n_s4_min  = 6'(r_s3_q - n_s4_qx60);

        n_s6_days = r_s5_prod[DivShift24 +: 16];
        n_s6_dx24 = (21'(n_s6_days) << 4) + (21'(n_s6_days) << 3);
        n_s6_hour = 5'(r_s5_q - n_s6_dx24);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_t        <= i_seconds;
        r_s1_prod     <= 64'(i_seconds) * 64'(DivMagic60);

        r_s2_q        <= n_s2_q;
        r_s2_sec      <= n_s2_sec;

        r_s3_q        <= r_s2_q;
        r_s3_prod     <= 59'(r_s2_q) * 59'(DivMagic60);
        r_s3_sec      <= r_s2_sec;

        r_s4_q        <= n_s4_q;
        r_s4_sec      <= r_s3_sec;
        r_s4_min      <= n_s4_min;

        r_s5_q        <= r_s4_q;
        r_s5_prod     <= 53'(r_s4_q) * 53'(DivMagic24);
        r_s5_sec      <= r_s4_sec;
        r_s5_min      <= r_s4_min;

        r_s6_days     <= n_s6_days;
        r_s6_hms.sec  <= r_s5_sec;
        r_s6_hms.min  <= r_s5_min;
        r_s6_hms.hour <= n_s6_hour;
    end

    assign o_valid = r_s6_valid;
    assign o_days  = r_s6_days;
    assign o_hms   = r_s6_hms;

endmodule

`default_nettype wire

/* src/ecd_date_split.sv */
// ----------------------------------------------------------------------------
// ecd_date_split
// Five-stage pipeline that turns a day count since 1970 into year offset,
// month and day of month, carrying the time of day alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_date_split
    import ecd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_days i_days,
    input  wire t_hms  i_hms,
    output logic       o_valid,
    output t_year      o_year,
    output logic [3:0] o_month,
    output logic [4:0] o_day,
    output t_hms       o_hms
);

    logic        r_s1_valid;
    t_days       r_s1_days;
    logic [31:0] r_s1_prod;
    t_hms        r_s1_hms;

    logic        r_s2_valid;
    t_days       r_s2_days;
    t_year       r_s2_year;
    t_days       r_s2_start_lo;
    t_days       r_s2_start_mid;
    t_days       r_s2_start_hi;
    t_hms        r_s2_hms;

    logic        r_s3_valid;
    t_year       r_s3_year;
    t_doy        r_s3_doy;
    logic        r_s3_leap;
    t_hms        r_s3_hms;

    logic        r_s4_valid;
    t_year       r_s4_year;
    t_doy        r_s4_doy;
    t_month_idx  r_s4_idx;
    t_doy        r_s4_mstart;
    t_hms        r_s4_hms;

    logic        r_s5_valid;
    t_year       r_s5_year;
    logic [3:0]  r_s5_month;
    logic [4:0]  r_s5_day;
    t_hms        r_s5_hms;

    t_year       n_s2_year;
    t_year       n_s2_year_lo;
    t_year       n_s3_year;
    t_days       n_s3_doy;
    t_month_idx  n_s4_idx;

    always_comb begin
        n_s2_year    = r_s1_prod[YearShift +: 8];
        n_s2_year_lo = (n_s2_year == 8'd0) ? 8'd0 : n_s2_year - 8'd1;

        if (r_s2_days >= r_s2_start_hi) begin
            n_s3_year = r_s2_year + 8'd1;
            n_s3_doy  = r_s2_days - r_s2_start_hi;
        end else if (r_s2_days >= r_s2_start_mid) begin
            n_s3_year = r_s2_year;
            n_s3_doy  = r_s2_days - r_s2_start_mid;
        end else begin
            n_s3_year = r_s2_year - 8'd1;
            n_s3_doy  = r_s2_days - r_s2_start_lo;
        end

        n_s4_idx = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r_s3_doy >= month_start(t_month_idx'(m), r_s3_leap)) begin
                n_s4_idx = t_month_idx'(m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_days      <= i_days;
        r_s1_prod      <= 32'(i_days) * 32'(YearMagic);
        r_s1_hms       <= i_hms;

        r_s2_days      <= r_s1_days;
        r_s2_year      <= n_s2_year;
        r_s2_start_lo  <= year_start(n_s2_year_lo);
        r_s2_start_mid <= year_start(n_s2_year);
        r_s2_start_hi  <= year_start(n_s2_year + 8'd1);
        r_s2_hms       <= r_s1_hms;

        r_s3_year      <= n_s3_year;
        r_s3_doy       <= t_doy'(n_s3_doy);
        r_s3_leap      <= is_leap(n_s3_year);
        r_s3_hms       <= r_s2_hms;

        r_s4_year      <= r_s3_year;
        r_s4_doy       <= r_s3_doy;
        r_s4_idx       <= n_s4_idx;
        r_s4_mstart    <= month_start(n_s4_idx, r_s3_leap);
        r_s4_hms       <= r_s3_hms;

        r_s5_year      <= r_s4_year;
        r_s5_month     <= r_s4_idx + 4'd1;
        r_s5_day       <= 5'(r_s4_doy - r_s4_mstart + 9'd1);
        r_s5_hms       <= r_s4_hms;
    end

    assign o_valid = r_s5_valid;
    assign o_year  = r_s5_year;
    assign o_month = r_s5_month;
    assign o_day   = r_s5_day;
    assign o_hms   = r_s5_hms;

endmodule

`default_nettype wire

/* src/epoch_seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// Output: the result of each start transfer is presented after the pipeline,
// with o_valid high for one cycle.
// Throughput: one conversion per cycle; busy stays low, since the eleven
// pipeline stages each take a new item every cycle.
// Reset clears only the stage valid bits; no result is produced from it.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_date
    import ecd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    output logic [5:0]       o_second_of_minute,
    output logic [5:0]       o_minute_of_hour,
    output logic [4:0]       o_hour_of_day,
    output logic [7:0]       o_year_since_1970,
    output logic [3:0]       o_month_number,
    output logic [4:0]       o_day_of_month
);

    logic  accept;
    logic  time_valid;
    t_days time_days;
    t_hms  time_hms;
    t_hms  date_hms;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ecd_time_split u_time (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_seconds (i_epoch_seconds),
        .o_valid   (time_valid),
        .o_days    (time_days),
        .o_hms     (time_hms)
    );

    ecd_date_split u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (time_valid),
        .i_days  (time_days),
        .i_hms   (time_hms),
        .o_valid (o_valid),
        .o_year  (o_year_since_1970),
        .o_month (o_month_number),
        .o_day   (o_day_of_month),
        .o_hms   (date_hms)
    );

    assign o_second_of_minute = date_hms.sec;
    assign o_minute_of_hour   = date_hms.min;
    assign o_hour_of_day      = date_hms.hour;

endmodule

`default_nettype wire

/* src/ecd_checker.sv */
// ----------------------------------------------------------------------------
// ecd_checker
// Port-level checks of the converter: fixed latency and legal field values.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [31:0] i_epoch_seconds,
    input wire logic        o_valid,
    input wire logic [5:0]  o_second_of_minute,
    input wire logic [5:0]  o_minute_of_hour,
    input wire logic [4:0]  o_hour_of_day,
    input wire logic [7:0]  o_year_since_1970,
    input wire logic [3:0]  o_month_number,
    input wire logic [4:0]  o_day_of_month
);

    localparam int Latency = 11;

    // Every result stems from a transfer exactly the pipeline depth earlier.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start, Latency) && !$past(busy, Latency)))
        else $error("result without a matching transfer");

    a_transfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##Latency o_valid)
        else $error("transfer produced no result");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second_of_minute < 6'd60 && o_minute_of_hour < 6'd60 &&
                     o_hour_of_day < 5'd24 && o_year_since_1970 <= 8'd136))
        else $error("time field out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_number >= 4'd1 && o_month_number <= 4'd12 &&
                     o_day_of_month >= 5'd1 &&
                     (o_month_number != 4'd2 || o_day_of_month <= 5'd29)))
        else $error("date field out of range");

endmodule

bind epoch_seconds_to_calendar_date ecd_checker u_ecd_checker (.*);

`default_nettype wire

/* dv/tb_epoch_seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_date
// Self-checking testbench for the epoch seconds to calendar date converter.
// A queue of timestamps feeds a clocked driver that starts one conversion per
// transfer. Each accepted timestamp is converted by a behavioral calendar
// model that walks the years and months with the full Gregorian leap rule.
// The expected date goes into a queue. A clocked monitor compares every result
// strobe with the oldest expected date, field by field. Stimulus opens with
// calendar corner cases: epoch start, the largest input, leap days, the
// non-leap year 2100 and year ends. It then runs random timestamps: uniform
// values, day and month boundaries, and values near both ends of the range.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_epoch_seconds_to_calendar_date;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom  = 1850;
    localparam int MaxReports = 10;
    localparam int DrainWait  = 20;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
    } t_date;

    typedef struct {
        logic [31:0] secs;
        int          idle_pct;
    } t_request;

    typedef struct {
        logic [31:0] secs;
        t_date       date;
    } t_expected_date;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_epoch_seconds = '0;
    logic        o_valid;
    logic [5:0]  o_second_of_minute;
    logic [5:0]  o_minute_of_hour;
    logic [4:0]  o_hour_of_day;
    logic [7:0]  o_year_since_1970;
    logic [3:0]  o_month_number;
    logic [4:0]  o_day_of_month;

    t_request       conversion_requests[$];
    t_expected_date expected_dates[$];
    int             accepted_count;
    int             checked_count;
    int             mismatch_count;
    int             latest_year;

    epoch_seconds_to_calendar_date dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_year_since_1970  (o_year_since_1970),
        .o_month_number     (o_month_number),
        .o_day_of_month     (o_day_of_month)
    );

    function automatic bit gregorian_leap(input int unsigned year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function automatic int unsigned year_days(input int unsigned offset);
        return gregorian_leap(1970 + offset) ? 366 : 365;
    endfunction

    function automatic int unsigned month_days(input int unsigned offset,
                                               input int unsigned month);
        case (month)
            2:             return gregorian_leap(1970 + offset) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic t_date calendar_of(input logic [31:0] secs);
        t_date       d;
        int unsigned t;
        int unsigned offset;
        int unsigned month;
        t = secs;
        d.second = 6'(t % 60);
        t = t / 60;
        d.minute = 6'(t % 60);
        t = t / 60;
        d.hour = 5'(t % 24);
        t = t / 24;
        offset = 0;
        while (t >= year_days(offset)) begin
            t = t - year_days(offset);
            offset++;
        end
        month = 1;
        while ((month < 12) && (t >= month_days(offset, month))) begin
            t = t - month_days(offset, month);
            month++;
        end
        d.year  = 8'(offset);
        d.month = 4'(month);
        d.day   = 5'(t + 1);
        return d;
    endfunction

    function automatic logic [31:0] epoch_of(input int year, input int month, input int day,
                                             input int hh, input int mm, input int ss);
        longint days;
        days = longint'(day - 1);
        for (int y = 1970; y < year; y++) begin
            days += longint'(year_days(y - 1970));
        end
        for (int m = 1; m < month; m++) begin
            days += longint'(month_days(year - 1970, m));
        end
        return 32'(((days * 24 + hh) * 60 + mm) * 60 + ss);
    endfunction

    task automatic add_request(input logic [31:0] secs, input int idle_pct);
        t_request r;
        r.secs     = secs;
        r.idle_pct = idle_pct;
        conversion_requests.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Driver: a transfer completes at an edge where start is high and busy low.
    always @(posedge i_clk) begin
        t_request       r;
        t_expected_date e;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                e.secs = i_epoch_seconds;
                e.date = calendar_of(i_epoch_seconds);
                expected_dates.push_back(e);
                accepted_count++;
                if (int'(e.date.year) > latest_year) begin
                    latest_year = int'(e.date.year);
                end
            end
            if ((conversion_requests.size() != 0) &&
                ($urandom_range(99) >= conversion_requests[0].idle_pct)) begin
                r = conversion_requests.pop_front();
                start           <= 1'b1;
                i_epoch_seconds <= r.secs;
            end else begin
                start           <= 1'b0;
                i_epoch_seconds <= $urandom;
            end
        end
    end

    // Monitor: each strobed result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_date          got;
        t_expected_date e;
        if (i_rst_n && o_valid) begin
            got = '{o_second_of_minute, o_minute_of_hour, o_hour_of_day,
                    o_year_since_1970, o_month_number, o_day_of_month};
            if (expected_dates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MaxReports) begin
                    $display("ERROR: unexpected result y+%0d %0d-%0d %0d:%0d:%0d",
                             got.year, got.month, got.day, got.hour, got.minute,
                             got.second);
                end
            end else begin
                e = expected_dates.pop_front();
                checked_count++;
                if ((got.second != e.date.second) || (got.minute != e.date.minute) ||
                    (got.hour != e.date.hour) || (got.year != e.date.year) ||
                    (got.month != e.date.month) || (got.day != e.date.day)) begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports) begin
                        $display("ERROR: secs=%0d expected y+%0d %0d-%0d %0d:%0d:%0d, %s",
                                 e.secs, e.date.year, e.date.month, e.date.day,
                                 e.date.hour, e.date.minute, e.date.second,
                                 $sformatf("got y+%0d %0d-%0d %0d:%0d:%0d",
                                           got.year, got.month, got.day, got.hour,
                                           got.minute, got.second));
                    end
                end
            end
        end
    end

    initial begin
        int          idle_pct;
        int unsigned offset;
        int unsigned month;
        int unsigned day;
        logic [31:0] secs;
        accepted_count = 0;
        checked_count  = 0;
        mismatch_count = 0;
        latest_year    = 0;

        add_request(32'd0, 27);
        add_request(32'hFFFF_FFFF, 27);
        add_request(32'h8000_0000, 27);
        add_request(32'h7FFF_FFFF, 27);
        add_request(32'hAAAA_AAAA, 27);
        add_request(32'h5555_5555, 27);
        add_request(epoch_of(1970, 1, 31, 23, 59, 59), 27);
        add_request(epoch_of(1970, 12, 31, 23, 59, 59), 27);
        add_request(epoch_of(1972, 2, 29, 12, 30, 45), 27);
        add_request(epoch_of(1972, 3, 1, 0, 0, 0), 27);
        add_request(epoch_of(1972, 12, 31, 0, 0, 0), 27);
        add_request(epoch_of(2000, 2, 29, 23, 59, 59), 27);
        add_request(epoch_of(2000, 3, 1, 0, 0, 0), 27);
        add_request(epoch_of(2038, 1, 19, 3, 14, 7), 27);
        add_request(epoch_of(2096, 2, 29, 6, 0, 0), 27);
        add_request(epoch_of(2100, 2, 28, 23, 59, 59), 27);
        add_request(epoch_of(2100, 3, 1, 0, 0, 0), 27);
        add_request(epoch_of(2100, 12, 31, 23, 59, 59), 27);
        add_request(epoch_of(2105, 12, 31, 23, 59, 59), 27);
        add_request(epoch_of(2106, 1, 1, 0, 0, 0), 27);

        for (int i = 0; i < NumRandom; i++) begin
            if (i < NumRandom / 3) begin
                idle_pct = 27;
            end else if (i < 2 * NumRandom / 3) begin
                idle_pct = 68;
            end else begin
                idle_pct = 0;
            end
            case ($urandom_range(9))
                0, 1, 2, 3: secs = $urandom;
                4, 5, 6: begin
                    offset = $urandom_range(0, 135);
                    month  = $urandom_range(1, 12);
                    day    = $urandom_range(1) ? 1 : month_days(offset, month);
                    if ($urandom_range(1)) begin
                        secs = epoch_of(1970 + offset, month, day, 0, 0, 0);
                    end else begin
                        secs = epoch_of(1970 + offset, month, day, 23, 59, 59);
                    end
                end
                7, 8: secs = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
                default: secs = $urandom_range(0, 200_000);
            endcase
            add_request(secs, idle_pct);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((conversion_requests.size() != 0) || start) begin
            @(posedge i_clk);
        end
        while (expected_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainWait) @(posedge i_clk);

        $display("Converted %0d timestamps and checked %0d dates, up to year offset %0d.",
                 accepted_count, checked_count, latest_year);
        $display("Mismatches: %0d, results still outstanding: %0d.",
                 mismatch_count, expected_dates.size());
        if ((mismatch_count == 0) && (expected_dates.size() == 0)) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/ecd_pkg.sv
src/ecd_time_split.sv
src/ecd_date_split.sv
src/epoch_seconds_to_calendar_date.sv
src/ecd_checker.sv
dv/tb_epoch_seconds_to_calendar_date.sv
